### hdl/gtcr_pkg.sv
`default_nettype none

package gtcr_pkg;

    // Font geometry
    localparam int GLYPH_HEIGHT = 16;
    localparam int GLYPH_WIDTH  = 8;
    localparam int CHAR_COUNT   = 256;

    localparam int ROW_W     = $clog2(GLYPH_HEIGHT);
    localparam int CODE_W    = $clog2(CHAR_COUNT);
    localparam int FONT_AW   = CODE_W + ROW_W;
    localparam int FONT_DEPTH = CHAR_COUNT * GLYPH_HEIGHT;

    // Cursor positions are 13 bits wide
    localparam int POS_W = 13;

    // Operation codes
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_PRINT  = 2'd1;
    localparam logic [1:0] OP_CURSOR = 2'd2;

    // Character codes with special meaning
    localparam logic [7:0] CODE_NEWLINE = 8'd10;
    localparam logic [7:0] CODE_HIGH    = 8'd128;

    // Configuration register indexes
    localparam logic [2:0] REG_BASE   = 3'd0;
    localparam logic [2:0] REG_WIDTH  = 3'd1;
    localparam logic [2:0] REG_HEIGHT = 3'd2;
    localparam logic [2:0] REG_PITCH  = 3'd3;
    localparam logic [2:0] REG_BPP    = 3'd4;
    localparam logic [2:0] REG_FG     = 3'd5;
    localparam logic [2:0] REG_BG     = 3'd6;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  char_code;
        logic [3:0]  glyph_row;
        logic [7:0]  glyph_bits;
        logic [11:0] new_x;
        logic [11:0] new_y;
    } in_item_t;

    typedef struct packed {
        logic [31:0] row_address;
        logic [7:0]  pixel_enable;
        logic [31:0] color_0;
        logic [31:0] color_1;
        logic [31:0] color_2;
        logic [31:0] color_3;
        logic [31:0] color_4;
        logic [31:0] color_5;
        logic [31:0] color_6;
        logic [31:0] color_7;
        logic        last_row;
    } out_item_t;

endpackage

`default_nettype wire

### hdl/glyph_text_console_renderer.sv
`default_nettype none

// The first row of a printed character passes the row sequencer, the font read and
// middle stage, then the output register. Rows go one per cycle unless m_ready stalls,
// set by the single font read port; loads, cursor moves and newlines start no reads.
// Reset (synchronous, aresetn low): registers take their defaults, cursor goes to 0,0,
// the pipeline empties; the font store is not cleared and holds garbage until loaded.
module glyph_text_console_renderer (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      s_valid,
    output logic                     s_ready,
    input  gtcr_pkg::in_item_t       s_payload,
    output logic                     m_valid,
    input  wire                      m_ready,
    output gtcr_pkg::out_item_t      m_payload,
    input  wire                      cfg_valid,
    output logic                     cfg_ready,
    input  wire  [2:0]               cfg_index,
    input  wire  [31:0]              cfg_data
);
    import gtcr_pkg::*;

    // Configuration registers
    logic [31:0]      base_reg;
    logic [POS_W-1:0] width_reg;
    logic [POS_W-1:0] height_reg;
    logic [15:0]      pitch_reg;
    logic [2:0]       bpp_reg;
    logic [31:0]      fg_reg;
    logic [31:0]      bg_reg;

    // Cursor
    logic [POS_W-1:0] col_reg, col_next;
    logic [POS_W-1:0] line_reg, line_next;

    // Row sequencer
    logic             busy_reg, busy_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [CODE_W-1:0] code_reg;
    logic [POS_W-1:0] col_snap_reg;
    logic [POS_W-1:0] line_snap_reg;

    // Font store and its read data
    logic [7:0]       font_mem [FONT_DEPTH];
    logic [7:0]       rd_data_reg;

    // Middle stage
    logic             s1_valid_reg;
    logic [29:0]      s1_prod_reg;
    logic [15:0]      s1_coloff_reg;
    logic [7:0]       s1_enable_reg;
    logic             s1_last_reg;

    // Output stage
    logic             out_valid_reg;
    out_item_t        out_reg;

    logic             s_xfer, out_free, s1_free, issue, last_issue;
    logic             do_print, do_load;
    logic [POS_W:0]   cur_line;
    logic [29:0]      prod;
    logic [15:0]      coloff;
    logic [7:0]       enable;
    logic [POS_W-1:0] adv_col, step_line, mid_line;

    assign cfg_ready = 1'b1;

    // Pipeline handshakes
    assign out_free   = !out_valid_reg || m_ready;
    assign s1_free    = !s1_valid_reg || out_free;
    assign issue      = busy_reg && s1_free;
    assign last_issue = issue && (row_reg == ROW_W'(GLYPH_HEIGHT - 1));
    assign s_ready    = !busy_reg || last_issue;
    assign s_xfer     = s_valid && s_ready;

    assign do_print = s_xfer && (s_payload.operation == OP_PRINT)
                      && (s_payload.char_code < CODE_HIGH)
                      && (s_payload.char_code != CODE_NEWLINE);
    assign do_load  = s_xfer && (s_payload.operation == OP_LOAD)
                      && ({1'b0, s_payload.char_code} < 9'(CHAR_COUNT))
                      && ({2'b00, s_payload.glyph_row} < 6'(GLYPH_HEIGHT));

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg   <= '0;
            width_reg  <= POS_W'(1024);
            height_reg <= POS_W'(768);
            pitch_reg  <= 16'd4096;
            bpp_reg    <= 3'd4;
            fg_reg     <= 32'h00FF_FFFF;
            bg_reg     <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_BASE:   base_reg   <= cfg_data;
                REG_WIDTH:  width_reg  <= cfg_data[POS_W-1:0];
                REG_HEIGHT: height_reg <= cfg_data[POS_W-1:0];
                REG_PITCH:  pitch_reg  <= cfg_data[15:0];
                REG_BPP:    bpp_reg    <= cfg_data[2:0];
                REG_FG:     fg_reg     <= cfg_data;
                REG_BG:     bg_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // Cursor update: advance after a glyph, wrap at the edges, move on newline, load on set cursor
    always_comb begin
        adv_col   = col_reg + POS_W'(GLYPH_WIDTH);
        step_line = line_reg + POS_W'(GLYPH_HEIGHT);
        col_next  = col_reg;
        line_next = line_reg;
        mid_line  = line_reg;
        if (s_xfer) begin
            case (s_payload.operation)
                OP_CURSOR: begin
                    col_next  = POS_W'(s_payload.new_x);
                    line_next = POS_W'(s_payload.new_y);
                end
                OP_PRINT: begin
                    if (s_payload.char_code < CODE_HIGH) begin
                        if (s_payload.char_code == CODE_NEWLINE) begin
                            col_next = '0;
                            mid_line = step_line;
                        end else if (({1'b0, adv_col} + (POS_W+1)'(GLYPH_WIDTH))
                                     > {1'b0, width_reg}) begin
                            col_next = '0;
                            mid_line = step_line;
                        end else begin
                            col_next = adv_col;
                        end
                        if (({1'b0, mid_line} + (POS_W+1)'(GLYPH_HEIGHT))
                            > {1'b0, height_reg}) begin
                            line_next = '0;
                        end else begin
                            line_next = mid_line;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            line_reg <= '0;
        end else begin
            col_reg  <= col_next;
            line_reg <= line_next;
        end
    end

    // Sequencer: start on a print, step one row per issued read
    always_comb begin
        busy_next = busy_reg;
        row_next  = row_reg;
        if (issue) begin
            row_next = row_reg + 1'b1;
            if (last_issue) begin
                busy_next = 1'b0;
            end
        end
        if (do_print) begin
            busy_next = 1'b1;
            row_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            row_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            row_reg  <= row_next;
        end
    end

    // Snapshot character and cursor at print transfer
    always_ff @(posedge aclk) begin
        if (do_print) begin
            code_reg      <= s_payload.char_code[CODE_W-1:0];
            col_snap_reg  <= col_reg;
            line_snap_reg <= line_reg;
        end
    end

    // Font store: write on load, read one glyph row per issue
    always_ff @(posedge aclk) begin
        if (do_load) begin
            font_mem[{s_payload.char_code[CODE_W-1:0], s_payload.glyph_row[ROW_W-1:0]}]
                <= s_payload.glyph_bits;
        end
        if (issue) begin
            rd_data_reg <= font_mem[{code_reg, row_reg}];
        end
    end

    // Row geometry for the issued row
    always_comb begin
        cur_line = {1'b0, line_snap_reg} + (POS_W+1)'(row_reg);
        prod     = 30'(cur_line) * 30'(pitch_reg);
        coloff   = 16'(col_snap_reg) * 16'(bpp_reg);
        for (int n = 0; n < 8; n++) begin
            enable[n] = (({1'b0, col_snap_reg} + (POS_W+1)'(n)) < {1'b0, width_reg})
                        && (cur_line < {1'b0, height_reg});
        end
    end

    // Middle stage: hold geometry beside the font read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_free) begin
            s1_valid_reg <= issue;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            s1_prod_reg   <= prod;
            s1_coloff_reg <= coloff;
            s1_enable_reg <= enable;
            s1_last_reg   <= (row_reg == ROW_W'(GLYPH_HEIGHT - 1));
        end
    end

    // Output register: final address and pixel colors
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && s1_valid_reg) begin
            out_reg.row_address  <= base_reg + 32'(s1_prod_reg) + 32'(s1_coloff_reg);
            out_reg.pixel_enable <= s1_enable_reg;
            out_reg.color_0      <= rd_data_reg[7] ? fg_reg : bg_reg;
            out_reg.color_1      <= rd_data_reg[6] ? fg_reg : bg_reg;
            out_reg.color_2      <= rd_data_reg[5] ? fg_reg : bg_reg;
            out_reg.color_3      <= rd_data_reg[4] ? fg_reg : bg_reg;
            out_reg.color_4      <= rd_data_reg[3] ? fg_reg : bg_reg;
            out_reg.color_5      <= rd_data_reg[2] ? fg_reg : bg_reg;
            out_reg.color_6      <= rd_data_reg[1] ? fg_reg : bg_reg;
            out_reg.color_7      <= rd_data_reg[0] ? fg_reg : bg_reg;
            out_reg.last_row     <= s1_last_reg;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = out_reg;

    // No new item while rows of a character are still to be read
    a_no_accept_mid_char: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && (row_reg != ROW_W'(GLYPH_HEIGHT - 1)) |-> !s_ready)
        else $error("input taken in the middle of a character");

    // A character always starts at its first row
    a_start_row_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(busy_reg) |-> (row_reg == '0))
        else $error("character started at a nonzero row");

    // An issued read always lands in the middle stage
    a_issue_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        issue |=> s1_valid_reg)
        else $error("issued row lost");

    // A stalled middle stage keeps its row
    a_s1_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !out_free |=> s1_valid_reg && $stable(s1_prod_reg)
                                      && $stable(rd_data_reg))
        else $error("middle stage changed while stalled");

endmodule

`default_nettype wire
